### hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared types, constants and helper functions for the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH         = 128;
    localparam int MAX_FRACTION_DIGITS = 8;
    localparam int PTR_W               = $clog2(STACK_DEPTH);
    localparam int CNT_W               = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W               = 48;
    localparam int FD_W                = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_TIMES = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] INT_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_NUM   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_OP   = 2'd1,
        KIND_NUM  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_READ,
        EX_WAIT,
        EX_CALC,
        EX_MUL,
        EX_DIV,
        EX_DONE
    } ex_state_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_token;
        logic       end_of_expression;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] top_value;
        logic [7:0]         stack_depth;
        logic [1:0]         status;
        logic               expression_done;
    } out_word_t;

    // One finished token as handed from the parser to the execution unit.
    typedef struct packed {
        logic          is_op;
        op_t           op;
        logic          bad;
        logic [31:0]   int_part;
        logic [31:0]   frac_digits;
        logic [FD_W-1:0] frac_count;
        logic          eox;
    } token_t;

    function automatic logic [31:0] pow_ten(input logic [FD_W-1:0] k);
        logic [31:0] r;
        begin
            case (k)
                4'd0:    r = 32'd1;
                4'd1:    r = 32'd10;
                4'd2:    r = 32'd100;
                4'd3:    r = 32'd1000;
                4'd4:    r = 32'd10000;
                4'd5:    r = 32'd100000;
                4'd6:    r = 32'd1000000;
                4'd7:    r = 32'd10000000;
                4'd8:    r = 32'd100000000;
                default: r = 32'd1000000000;
            endcase
            return r;
        end
    endfunction

endpackage

### hw/rtl/rpn_fixed_point_evaluator.sv
// ----------------------------------------------------------------------------
// RPN fixed-point evaluator
// Top level: parser front end, token queue and execution back end.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Word
//   in        input      in_valid / in_ready       rpn_pkg::in_word_t
//   out       output     out_valid / out_ready     rpn_pkg::out_word_t
//
// A character that does not end a token is absorbed whenever the token queue
// has room. A token end runs in the execution unit; a number with fraction
// digits is scaled by dividing its fraction by ten once per digit, upper bits
// first, then the remainder with the lower bits. The stack sits in a
// single-port-write memory with a registered read. Reset clears the control
// state and the stack count; stack entries are not cleared and are only read
// below the count. A two-entry token queue lets the parser keep taking
// characters while the back end works; the result register holds a word until
// it is taken, and the back end waits on a full register.
//
module rpn_fixed_point_evaluator (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::in_word_t  in_word,
    input  logic               in_valid,
    output logic               in_ready,
    output rpn_pkg::out_word_t out_word,
    output logic               out_valid,
    input  logic               out_ready
);

    // Completed tokens travel from the parser through the queue.
    rpn_pkg::token_t p_tok;
    logic            p_valid;
    logic            p_ready;
    rpn_pkg::token_t q_tok;
    logic            q_valid;
    logic            q_ready;

    rpn_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .tok       (p_tok),
        .tok_valid (p_valid),
        .tok_ready (p_ready)
    );

    rpn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_tok   (p_tok),
        .wr_valid (p_valid),
        .wr_ready (p_ready),
        .rd_tok   (q_tok),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    rpn_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_tok),
        .tok_valid (q_valid),
        .tok_ready (q_ready),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word dropped while stalled");
    a_status_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == rpn_pkg::ST_OVERFLOW
        |-> 32'(out_word.stack_depth) == (rpn_pkg::STACK_DEPTH % 256))
        else $error("overflow reported below full depth");
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.stack_depth == 8'd0 |-> out_word.top_value == '0)
        else $error("empty stack reports nonzero top");
`endif

endmodule

### hw/rtl/rpn_parser.sv
// ----------------------------------------------------------------------------
// RPN token parser
// Accepts characters, accumulates one token and emits it when it ends.
// ----------------------------------------------------------------------------
module rpn_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::in_word_t in_word,
    input  logic              in_valid,
    output logic              in_ready,
    output rpn_pkg::token_t   tok,
    output logic              tok_valid,
    input  logic              tok_ready
);

    rpn_pkg::kind_t          kind_reg, kind_next;
    rpn_pkg::op_t            op_reg, op_next;
    logic                    point_reg, point_next;
    logic                    err_reg, err_next;
    logic [31:0]             int_reg, int_next;
    logic [31:0]             frac_reg, frac_next;
    logic [rpn_pkg::FD_W-1:0] fcnt_reg, fcnt_next;
    logic                    is_digit;
    logic [3:0]              digit;
    logic [35:0]             int_x10;
    logic [35:0]             frac_x10;
    logic                    eot;
    logic                    accept;
    logic                    number_char;
    rpn_pkg::token_t         tok_next;

    // The token can only be completed when the queue has room.
    assign in_ready = tok_ready;
    assign accept   = in_valid && in_ready;
    assign eot      = in_word.end_of_token || in_word.end_of_expression;
    assign is_digit = (in_word.character >= rpn_pkg::CH_ZERO) &&
                      (in_word.character <= rpn_pkg::CH_NINE);
    assign digit    = in_word.character[3:0] - rpn_pkg::CH_ZERO[3:0];
    assign int_x10  = {4'd0, int_reg} * 36'd10 + {32'd0, digit};
    assign frac_x10 = {4'd0, frac_reg} * 36'd10 + {32'd0, digit};

    always_comb
    begin
        kind_next   = kind_reg;
        op_next     = op_reg;
        point_next  = point_reg;
        err_next    = err_reg;
        int_next    = int_reg;
        frac_next   = frac_reg;
        fcnt_next   = fcnt_reg;
        number_char = 1'b0;
        if (kind_reg == rpn_pkg::KIND_IDLE) begin
            if (in_word.character == rpn_pkg::CH_PLUS) begin
                kind_next = rpn_pkg::KIND_OP;
                op_next   = rpn_pkg::OP_ADD;
            end else if (in_word.character == rpn_pkg::CH_TIMES) begin
                kind_next = rpn_pkg::KIND_OP;
                op_next   = rpn_pkg::OP_MUL;
            end else if (in_word.character == rpn_pkg::CH_MINUS) begin
                kind_next = rpn_pkg::KIND_OP;
                op_next   = rpn_pkg::OP_SUB;
            end else begin
                kind_next   = rpn_pkg::KIND_NUM;
                number_char = 1'b1;
            end
        end else if (kind_reg == rpn_pkg::KIND_NUM) begin
            number_char = 1'b1;
        end
        if (number_char) begin
            if (is_digit) begin
                if (!point_reg) begin
                    if (int_x10 > {4'd0, rpn_pkg::INT_LIMIT}) begin
                        int_next = rpn_pkg::INT_LIMIT;
                    end else begin
                        int_next = int_x10[31:0];
                    end
                end else if ((32'(fcnt_reg) < 32'(rpn_pkg::MAX_FRACTION_DIGITS)) &&
                             (fcnt_reg < rpn_pkg::FD_W'(9))) begin
                    frac_next = frac_x10[31:0];
                    fcnt_next = fcnt_reg + rpn_pkg::FD_W'(1);
                end
            end else if (in_word.character == rpn_pkg::CH_POINT && !point_reg) begin
                point_next = 1'b1;
            end else begin
                err_next = 1'b1;
            end
        end
        tok_next.is_op       = (kind_next == rpn_pkg::KIND_OP);
        tok_next.op          = op_next;
        tok_next.bad         = err_next;
        tok_next.int_part    = int_next;
        tok_next.frac_digits = frac_next;
        tok_next.frac_count  = fcnt_next;
        tok_next.eox         = in_word.end_of_expression;
    end

    assign tok       = tok_next;
    assign tok_valid = in_valid && eot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg  <= rpn_pkg::KIND_IDLE;
            op_reg    <= rpn_pkg::OP_ADD;
            point_reg <= 1'b0;
            err_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
        end else if (accept) begin
            if (eot) begin
                kind_reg  <= rpn_pkg::KIND_IDLE;
                op_reg    <= rpn_pkg::OP_ADD;
                point_reg <= 1'b0;
                err_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                fcnt_reg  <= '0;
            end else begin
                kind_reg  <= kind_next;
                op_reg    <= op_next;
                point_reg <= point_next;
                err_reg   <= err_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                fcnt_reg  <= fcnt_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_int_limit: assert property (@(posedge clk) disable iff (!rst_n)
        !int_reg[31])
        else $error("integer accumulator exceeded limit");
    a_fcnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fcnt_reg) <= rpn_pkg::MAX_FRACTION_DIGITS)
        else $error("fraction digit count exceeded limit");
    a_op_clean: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg == rpn_pkg::KIND_OP |-> !point_reg && !err_reg)
        else $error("operator token carries number state");
`endif

endmodule

### hw/rtl/rpn_queue.sv
// ----------------------------------------------------------------------------
// RPN token queue
// Two-entry queue that decouples the parser from the execution unit.
// ----------------------------------------------------------------------------
module rpn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  rpn_pkg::token_t wr_tok,
    input  logic            wr_valid,
    output logic            wr_ready,
    output rpn_pkg::token_t rd_tok,
    output logic            rd_valid,
    input  logic            rd_ready
);

    rpn_pkg::token_t slot_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            wr_en, rd_en;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_tok   = slot_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wp_reg] <= wr_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent with count");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |=> cnt_reg != 2'd0)
        else $error("queue drained too fast");
`endif

endmodule

### hw/rtl/rpn_exec.sv
// ----------------------------------------------------------------------------
// RPN execution unit
// Owns the value stack, runs arithmetic and the fraction scaling, and
// produces one result word per token.
// ----------------------------------------------------------------------------
module rpn_exec (
    input  logic               clk,
    input  logic               rst_n,
    input  rpn_pkg::token_t    tok,
    input  logic               tok_valid,
    output logic               tok_ready,
    output rpn_pkg::out_word_t out_word,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int PW = rpn_pkg::PTR_W;
    localparam int CW = rpn_pkg::CNT_W;

    // Reciprocal of ten: floor(n / 10) == (n * DIV10_MAGIC) >> 35 for any 32-bit n.
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

    logic signed [47:0] mem [rpn_pkg::STACK_DEPTH];

    rpn_pkg::ex_state_t state_reg, state_next;
    rpn_pkg::token_t    tok_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [47:0] t_reg, s_reg, rd_data;
    logic signed [47:0] res_reg;
    logic [PW-1:0]      rd_addr;
    logic               rd_en;
    logic [5:0]         step_reg;
    logic               neg_reg;
    logic [47:0]        ua_reg;
    logic [31:0]        hi_reg;
    logic [15:0]        lo_reg;
    logic [63:0]        p_hi_reg, p_lo_reg;
    logic [47:0]        p_top_reg;
    logic [47:0]        quo_reg;
    logic               div_ph_reg;
    logic               out_valid_reg;
    rpn_pkg::out_word_t out_reg;

    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic signed [47:0] wr_data;
    logic [CW-1:0]      cnt_after;
    logic [1:0]         st_code;
    logic signed [49:0] sum_w;
    logic signed [47:0] sum_sat;
    logic [81:0]        mag_w;
    logic [48:0]        mag_sat;
    logic signed [47:0] mul_sat;
    logic [28:0]        qh_w;
    logic [3:0]         rh_w;
    logic [19:0]        n_w;
    logic [51:0]        nq_w;
    logic [15:0]        ql_w;
    logic               done_fire;
    logic [47:0]        ub_w;

    localparam logic signed [47:0] VMAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] VMIN = {1'b1, {47{1'b0}}};

    assign tok_ready = (state_reg == rpn_pkg::EX_IDLE);
    assign done_fire = (state_reg == rpn_pkg::EX_DONE) && !out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::EX_IDLE: if (tok_valid) state_next = rpn_pkg::EX_READ;
            rpn_pkg::EX_READ: state_next = rpn_pkg::EX_WAIT;
            rpn_pkg::EX_WAIT: state_next = rpn_pkg::EX_CALC;
            rpn_pkg::EX_CALC:
            begin
                if (tok_reg.is_op && cnt_reg >= CW'(2) && tok_reg.op == rpn_pkg::OP_MUL)
                    state_next = rpn_pkg::EX_MUL;
                else if (!tok_reg.is_op && !tok_reg.bad &&
                         32'(cnt_reg) < rpn_pkg::STACK_DEPTH &&
                         tok_reg.frac_count != '0)
                    state_next = rpn_pkg::EX_DIV;
                else
                    state_next = rpn_pkg::EX_DONE;
            end
            rpn_pkg::EX_MUL: state_next = rpn_pkg::EX_DONE;
            rpn_pkg::EX_DIV: if (step_reg == 6'd0) state_next = rpn_pkg::EX_DONE;
            rpn_pkg::EX_DONE: if (!out_valid_reg) state_next = rpn_pkg::EX_IDLE;
            default: state_next = rpn_pkg::EX_IDLE;
        endcase
    end

    // Stack read address: top then second in successive cycles.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            rpn_pkg::EX_IDLE:
            begin
                rd_en   = 1'b1;
                rd_addr = PW'(cnt_reg - CW'(1));
            end
            rpn_pkg::EX_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = PW'(cnt_reg - CW'(2));
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) rd_data <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    // Add and subtract with saturation.
    always_comb
    begin
        if (tok_reg.op == rpn_pkg::OP_ADD)
            sum_w = 50'(s_reg) + 50'(t_reg);
        else
            sum_w = 50'(s_reg) - 50'(t_reg);
        if (sum_w > 50'(VMAX))      sum_sat = VMAX;
        else if (sum_w < 50'(VMIN)) sum_sat = VMIN;
        else                        sum_sat = sum_w[47:0];
    end

    assign ub_w = t_reg[47] ? 48'(-t_reg) : 48'(t_reg);

    // Product magnitude: ua*hi + (ua*lo >> 16), capped at 2^48. The ua*hi term
    // is split at bit 32 of ua so that each multiplier stays narrow.
    always_comb
    begin
        mag_w = 82'(p_hi_reg) + (82'(p_top_reg) << 32) + 82'(p_lo_reg >> 16);
        if (mag_w > 82'(49'h1_0000_0000_0000)) mag_sat = 49'h1_0000_0000_0000;
        else                                    mag_sat = mag_w[48:0];
        if (neg_reg) begin
            if (mag_sat >= 49'h0_8000_0000_0000) mul_sat = VMIN;
            else                                  mul_sat = -$signed(mag_sat[47:0]);
        end else begin
            if (mag_sat > 49'(VMAX)) mul_sat = VMAX;
            else                     mul_sat = mag_sat[47:0];
        end
    end

    // One division by ten of the scaled fraction: the upper 32
    // bits are divided first, then the remainder joins the lower 16 bits.
    // Repeating it k times divides by 10^k with the same truncation.
    assign qh_w = p_hi_reg[63:35];
    assign rh_w = quo_reg[19:16] - (qh_w[3:0] * 4'd10);
    assign n_w  = {rh_w, quo_reg[15:0]};
    assign nq_w = 52'(n_w) * 52'(DIV10_MAGIC);
    assign ql_w = nq_w[50:35];

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = '0;
        cnt_after = cnt_reg;
        st_code   = rpn_pkg::ST_OK;
        if (tok_reg.is_op) begin
            if (cnt_reg < CW'(2)) begin
                st_code = rpn_pkg::ST_UNDERFLOW;
            end else begin
                wr_en     = 1'b1;
                wr_addr   = PW'(cnt_reg - CW'(2));
                cnt_after = cnt_reg - CW'(1);
            end
        end else if (tok_reg.bad) begin
            st_code = rpn_pkg::ST_BAD_NUM;
        end else if (32'(cnt_reg) >= rpn_pkg::STACK_DEPTH) begin
            st_code = rpn_pkg::ST_OVERFLOW;
        end else begin
            wr_en     = 1'b1;
            wr_addr   = PW'(cnt_reg);
            cnt_after = cnt_reg + CW'(1);
        end
        wr_en = wr_en && done_fire;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rpn_pkg::EX_IDLE: if (tok_valid) tok_reg <= tok;
            rpn_pkg::EX_READ: t_reg <= rd_data;
            rpn_pkg::EX_WAIT: ;
            rpn_pkg::EX_CALC:
            begin
                s_reg      <= rd_data;
                neg_reg    <= rd_data[47] != t_reg[47];
                ua_reg     <= rd_data[47] ? 48'(-rd_data) : 48'(rd_data);
                hi_reg     <= ub_w[47:16];
                lo_reg     <= ub_w[15:0];
                res_reg    <= {16'd0, tok_reg.int_part} << 16;
                quo_reg    <= {tok_reg.frac_digits, 16'd0};
                step_reg   <= 6'(tok_reg.frac_count);
                div_ph_reg <= 1'b0;
                p_hi_reg   <= '0;
                p_lo_reg   <= '0;
                p_top_reg  <= '0;
            end
            rpn_pkg::EX_MUL:
            begin
                p_hi_reg  <= 64'(ua_reg[31:0]) * 64'(hi_reg);
                p_top_reg <= 48'(ua_reg[47:32]) * 48'(hi_reg);
                p_lo_reg  <= 64'(ua_reg) * 64'(lo_reg);
            end
            rpn_pkg::EX_DIV:
            begin
                if (step_reg != 6'd0) begin
                    if (!div_ph_reg) begin
                        p_hi_reg   <= 64'(quo_reg[47:16]) * 64'(DIV10_MAGIC);
                        div_ph_reg <= 1'b1;
                    end else begin
                        quo_reg    <= {3'd0, qh_w, ql_w};
                        step_reg   <= step_reg - 6'd1;
                        div_ph_reg <= 1'b0;
                    end
                end else begin
                    res_reg <= res_reg + quo_reg;
                end
            end
            rpn_pkg::EX_DONE: ;
            default: ;
        endcase
    end

    logic signed [47:0] final_val;
    always_comb
    begin
        final_val = res_reg;
        if (tok_reg.is_op) begin
            if (tok_reg.op == rpn_pkg::OP_MUL)
                final_val = mul_sat;
            else
                final_val = sum_sat;
        end
    end
    assign wr_data = final_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= rpn_pkg::EX_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (done_fire) begin
                out_valid_reg <= 1'b1;
                cnt_reg <= tok_reg.eox ? '0 : cnt_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire) begin
            out_reg.stack_depth     <= 8'(cnt_after);
            out_reg.status          <= st_code;
            out_reg.expression_done <= tok_reg.eox;
            if (wr_en)
                out_reg.top_value <= final_val;
            else if (cnt_reg == '0)
                out_reg.top_value <= '0;
            else
                out_reg.top_value <= t_reg;
        end
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= rpn_pkg::STACK_DEPTH)
        else $error("stack count beyond depth");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire && tok_reg.is_op && cnt_reg >= CW'(2) && !tok_reg.eox
        |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("operator did not shrink stack by one");
    a_eox_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_fire && tok_reg.eox |=> cnt_reg == '0)
        else $error("stack not cleared at expression end");
`endif

endmodule

### tb/sv/tb_rpn_fixed_point_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN fixed-point evaluator testbench
// Streams RPN expressions one character word at a time, predicts each token
// report with a behavioral stack machine and checks every output word.
// ----------------------------------------------------------------------------
module tb_rpn_fixed_point_evaluator;

    localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        rpn_pkg::in_word_t w;
        bit                drain;    // wait for every outstanding report before offering
    } pending_t;

    logic               clk;
    logic               rst_n;
    rpn_pkg::in_word_t  in_word;
    logic               in_valid;
    logic               in_ready;
    rpn_pkg::out_word_t out_word;
    logic               out_valid;
    logic               out_ready;

    pending_t           char_queue[$];
    rpn_pkg::out_word_t expected_reports[$];
    bit                 next_drain;
    bit                 failed;
    int                 chars_taken;
    int                 reports_seen;
    int                 hold_left;
    bit                 hold_done;

    // Behavioral copy of the evaluator state.
    logic signed [47:0] shadow_stack [rpn_pkg::STACK_DEPTH];
    int                 shadow_count;
    logic [31:0]        int_acc;
    logic [31:0]        frac_acc;
    int                 frac_digits;
    rpn_pkg::kind_t     kind;
    bit                 point_seen;
    bit                 bad_token;
    logic [7:0]         op_char;

    rpn_fixed_point_evaluator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_word (out_word),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint saturate(input longint v);
        if (v > VAL_MAX)
            return VAL_MAX;
        if (v < VAL_MIN)
            return VAL_MIN;
        return v;
    endfunction

    // Product on magnitudes, truncated toward zero by the Q16 shift, then signed.
    function automatic longint fixed_mul(input longint a, input longint b);
        bit neg;
        longint unsigned ua, ub, hi, lo, lim, r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        hi  = ub >> 16;
        lo  = ub & 64'hFFFF;
        lim = 64'd1 << 48;
        if (hi != 0 && ua > lim / hi)
            r = lim;
        else
        begin
            r = ua * hi + ((ua * lo) >> 16);
            if (r > lim)
                r = lim;
        end
        if (neg)
            return (r >= (64'd1 << 47)) ? VAL_MIN : -longint'(r);
        return (r > VAL_MAX) ? VAL_MAX : longint'(r);
    endfunction

    function automatic longint unsigned ten_to(input int k);
        longint unsigned p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    task automatic clear_token_state();
        int_acc     = '0;
        frac_acc    = '0;
        frac_digits = 0;
        kind        = rpn_pkg::KIND_IDLE;
        point_seen  = 1'b0;
        bad_token   = 1'b0;
        op_char     = '0;
    endtask

    task automatic parse_number_char(input logic [7:0] c);
        logic [31:0] d;
        if (c >= rpn_pkg::CH_ZERO && c <= rpn_pkg::CH_NINE)
        begin
            d = 32'(c - rpn_pkg::CH_ZERO);
            if (!point_seen)
                int_acc = (int_acc > (rpn_pkg::INT_LIMIT - d) / 10) ?
                          rpn_pkg::INT_LIMIT : int_acc * 10 + d;
            else if (frac_digits < rpn_pkg::MAX_FRACTION_DIGITS && frac_digits < 9)
            begin
                frac_acc    = frac_acc * 10 + d;
                frac_digits = frac_digits + 1;
            end
        end
        else if (c == rpn_pkg::CH_POINT && !point_seen)
            point_seen = 1'b1;
        else
            bad_token = 1'b1;
    endtask

    // Advances the shadow state by one accepted word and, at a token end, queues its report.
    task automatic evaluate_character(input rpn_pkg::in_word_t w);
        bit                 eot;
        rpn_pkg::status_t   st;
        longint             s, t, r;
        longint unsigned    frac;
        rpn_pkg::out_word_t rep;
        eot = w.end_of_token | w.end_of_expression;
        st  = rpn_pkg::ST_OK;
        if (kind == rpn_pkg::KIND_IDLE)
        begin
            if (w.character == rpn_pkg::CH_PLUS || w.character == rpn_pkg::CH_TIMES ||
                w.character == rpn_pkg::CH_MINUS)
            begin
                kind    = rpn_pkg::KIND_OP;
                op_char = w.character;
            end
            else
            begin
                kind = rpn_pkg::KIND_NUM;
                parse_number_char(w.character);
            end
        end
        else if (kind == rpn_pkg::KIND_NUM)
            parse_number_char(w.character);
        if (!eot)
            return;

        if (kind == rpn_pkg::KIND_OP)
        begin
            if (shadow_count < 2)
                st = rpn_pkg::ST_UNDERFLOW;
            else
            begin
                t = shadow_stack[shadow_count - 1];
                s = shadow_stack[shadow_count - 2];
                if (op_char == rpn_pkg::CH_PLUS)
                    r = saturate(s + t);
                else if (op_char == rpn_pkg::CH_TIMES)
                    r = fixed_mul(s, t);
                else
                    r = saturate(s - t);
                shadow_stack[shadow_count - 2] = r[47:0];
                shadow_count = shadow_count - 1;
            end
        end
        else if (bad_token)
            st = rpn_pkg::ST_BAD_NUM;
        else if (shadow_count >= rpn_pkg::STACK_DEPTH)
            st = rpn_pkg::ST_OVERFLOW;
        else
        begin
            frac = 0;
            if (frac_digits > 0)
                frac = ({32'd0, frac_acc} << 16) / ten_to(frac_digits);
            r = longint'(({32'd0, int_acc} << 16) + frac);
            shadow_stack[shadow_count] = r[47:0];
            shadow_count = shadow_count + 1;
        end

        rep.top_value       = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : '0;
        rep.stack_depth     = 8'(shadow_count);
        rep.status          = st;
        rep.expression_done = w.end_of_expression;
        expected_reports.push_back(rep);
        if (w.end_of_expression)
            shadow_count = 0;
        clear_token_state();
    endtask

    // Input side: offers queued words, idles about a third of the time except
    // during a quiet window, and holds back a drain-marked word until all
    // outstanding reports have come out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                evaluate_character(in_word);
                chars_taken = chars_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (char_queue.size() > 0 &&
                    !(char_queue[0].drain && expected_reports.size() != 0) &&
                    ((chars_taken > 900 && chars_taken < 1300) ||
                     $urandom_range(99) >= 32))
                begin
                    in_word  <= char_queue[0].w;
                    in_valid <= 1'b1;
                    void'(char_queue.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side: checks each report against the oldest prediction. Once,
    // ready is held low for a long stretch so the token queue backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                reports_seen = reports_seen + 1;
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report word, top_value %0d", out_word.top_value);
                    failed = 1'b1;
                end
                else
                begin
                    rpn_pkg::out_word_t e;
                    e = expected_reports.pop_front();
                    if (out_word.top_value !== e.top_value)
                    begin
                        $error("top_value expected %0d actual %0d",
                               e.top_value, out_word.top_value);
                        failed = 1'b1;
                    end
                    if (out_word.stack_depth !== e.stack_depth)
                    begin
                        $error("stack_depth expected %0d actual %0d",
                               e.stack_depth, out_word.stack_depth);
                        failed = 1'b1;
                    end
                    if (out_word.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, out_word.status);
                        failed = 1'b1;
                    end
                    if (out_word.expression_done !== e.expression_done)
                    begin
                        $error("expression_done expected %0d actual %0d",
                               e.expression_done, out_word.expression_done);
                        failed = 1'b1;
                    end
                end
            end
            if (!hold_done && reports_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (reports_seen > 500 && reports_seen < 700) ||
                             ($urandom_range(99) >= 32);
        end
    end

    task automatic emit_char(input logic [7:0] c, input bit eot, input bit eox);
        pending_t p;
        p.w.character         = c;
        p.w.end_of_token      = eot;
        p.w.end_of_expression = eox;
        p.drain               = next_drain;
        next_drain            = 1'b0;
        char_queue.push_back(p);
    endtask

    task automatic emit_str(input string s, input bit eox);
        for (int i = 0; i < s.len(); i++)
            emit_char(s[i], i == s.len() - 1, eox && (i == s.len() - 1));
    endtask

    // A decimal token: mostly short, now and then long enough to saturate the
    // integer part or run past the fraction digit limit.
    task automatic emit_number(input bit eox);
        int n_int, n_frac;
        bit point;
        logic [7:0] chars[$];
        n_int  = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
        point  = 1'($urandom_range(1));
        n_frac = point ? (($urandom_range(7) == 0) ? $urandom_range(11) : $urandom_range(3)) : 0;
        repeat (n_int) chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(9)));
        if (point)
            chars.push_back(rpn_pkg::CH_POINT);
        repeat (n_frac) chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(9)));
        if (chars.size() == 0)
            chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(9)));
        foreach (chars[i])
            emit_char(chars[i], i == chars.size() - 1, eox && (i == chars.size() - 1));
    endtask

    task automatic emit_operator(input bit eox);
        logic [7:0] ops[3];
        ops = '{rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS, rpn_pkg::CH_TIMES};
        emit_char(ops[$urandom_range(2)], 1'b1, eox);
    endtask

    // A well-formed expression with random content; the depth is tracked so
    // that every operator has two operands and it ends with one or two values.
    task automatic emit_expression();
        int depth, tokens;
        depth  = 0;
        tokens = 2 + $urandom_range(10);
        for (int i = 0; i < tokens; i++)
        begin
            if (depth >= 2 && $urandom_range(1))
            begin
                emit_operator(1'b0);
                depth = depth - 1;
            end
            else
            begin
                emit_number(1'b0);
                depth = depth + 1;
            end
        end
        while (depth > 2)
        begin
            emit_operator(1'b0);
            depth = depth - 1;
        end
        if (depth == 2)
            emit_operator(1'b1);
        else
            emit_number(1'b1);
    endtask

    // Noise: arbitrary bytes with random token and expression marks.
    task automatic emit_noise();
        repeat (1 + $urandom_range(6))
            emit_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(3) == 0);
    endtask

    initial
    begin
        failed       = 1'b0;
        next_drain   = 1'b0;
        chars_taken  = 0;
        reports_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        clear_token_state();
        shadow_count = 0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: each operator, underflow, bad numbers, a lone point,
        // a saturated integer part, a long fraction and an operator tail.
        emit_str("+", 1'b0);
        emit_str("2147483647999", 1'b0);
        emit_str("2147483647", 1'b0);
        emit_str("x", 1'b0);
        emit_str("0.99999999999", 1'b0);
        emit_str("-+x", 1'b0);
        emit_str(".", 1'b0);
        emit_str("1.2.3", 1'b0);
        emit_str("4a", 1'b0);
        emit_str("+", 1'b1);
        emit_str("0", 1'b0);
        emit_str("2147483647", 1'b0);
        emit_str("-", 1'b0);
        emit_str("2147483647", 1'b0);
        emit_str("x", 1'b0);
        emit_str("7.5", 1'b0);
        emit_str("-", 1'b1);
        // Expression end on a character without its token mark.
        emit_char(rpn_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0);
        emit_char(rpn_pkg::CH_POINT, 1'b0, 1'b1);

        // Fill the stack past its depth to reach the overflow report.
        next_drain = 1'b1;
        repeat (rpn_pkg::STACK_DEPTH + 2) emit_str("1", 1'b0);
        emit_str("+", 1'b1);

        // Random part: mostly well-formed expressions, some noise.
        while (char_queue.size() < 1900)
        begin
            if (char_queue.size() > 1000 && char_queue.size() < 1030)
                next_drain = 1'b1;
            if ($urandom_range(9) < 8)
                emit_expression();
            else
                emit_noise();
        end
        emit_str("0", 1'b1);

        wait (char_queue.size() == 0 && !in_valid);
        wait (expected_reports.size() == 0);
        repeat (200) @(posedge clk);
        if (!failed && expected_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
